// ----- hdl/lpf_pkg.sv -----
// ----------------------------------------------------------------------------
// Lookahead path follower package
// Shared types, codes and constants for the path follower and its CORDIC unit.
// ----------------------------------------------------------------------------
package lpf_pkg;

  localparam int IN_DATA_W  = 80;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_USER_W = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 31;

  localparam int CORDIC_STEPS = 30;
  localparam int CX_W         = 36;
  localparam int CZ_W         = 33;

  localparam logic [18:0] TWO_PI_Q16  = 19'd411775;
  localparam logic [31:0] CORDIC_K_Q30 = 32'd652032874;
  localparam logic [30:0] ONE_Q30      = 31'h4000_0000;
  localparam logic [15:0] QUARTER_TURN = 16'd16384;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_APPEND = 2'd1,
    OP_POSE   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CFG_LOOKAHEAD = 3'd0,
    CFG_GOAL_TOL  = 3'd1,
    CFG_MAX_LIN   = 3'd2,
    CFG_MAX_ANG   = 3'd3,
    CFG_LIN_GAIN  = 3'd4,
    CFG_ANG_GAIN  = 3'd5,
    CFG_TURN_THR  = 3'd6
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_G2, ST_L2, ST_L2W, ST_RD, ST_DIFF, ST_SQX, ST_SQY, ST_SUM,
    ST_SQRT, ST_BSTART, ST_BWAIT, ST_RAD, ST_RADW, ST_ANG, ST_LIN,
    ST_CSTART, ST_CWAIT, ST_MULC, ST_FIN, ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic vec;
  } cordic_ctl_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      default: a = 32'h0;
    endcase
    return a;
  endfunction

endpackage

// ----- hdl/lpf_cordic.sv -----
// ----------------------------------------------------------------------------
// Iterative CORDIC unit
// One micro-rotation per cycle, vectoring or rotation mode, 30 steps.
// ----------------------------------------------------------------------------
module lpf_cordic (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lpf_pkg::cordic_ctl_t                ctl,
  input  logic signed [lpf_pkg::CX_W-1:0]     x_in,
  input  logic signed [lpf_pkg::CX_W-1:0]     y_in,
  input  logic signed [lpf_pkg::CZ_W-1:0]     z_in,
  output logic                                busy,
  output logic signed [lpf_pkg::CX_W-1:0]     x_out,
  output logic signed [lpf_pkg::CZ_W-1:0]     z_out
);
  import lpf_pkg::*;

  logic signed [CX_W-1:0] x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic signed [CZ_W-1:0] z_r, z_nxt, a;
  logic [4:0]             step_r;
  logic                   busy_r, vec_r, plus;

  always_comb begin
    xs = x_r >>> step_r;
    ys = y_r >>> step_r;
    a  = $signed({1'b0, atan_turn(step_r)});
    plus = vec_r ? ~y_r[CX_W-1] : z_r[CZ_W-1];
    if (plus) begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + a;
    end else begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      vec_r  <= 1'b0;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
      step_r <= '0;
      vec_r  <= ctl.vec;
      x_r    <= x_in;
      y_r    <= y_in;
      z_r    <= z_in;
    end else if (busy_r) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      step_r <= step_r + 5'd1;
      if (step_r == 5'(CORDIC_STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy  = busy_r;
  assign x_out = x_r;
  assign z_out = z_r;

endmodule

// ----- hdl/lookahead_path_follower.sv -----
// ----------------------------------------------------------------------------
// Lookahead path follower
// Waypoint store with nearest-point search, lookahead target and speed commands.
// ----------------------------------------------------------------------------
// channel | direction | tdata / data          | tuser
// in_     | slave     | pos_x, pos_y, heading | opcode
// out_    | master    | linear, angular speed | at_goal, following
// cfg_    | write     | cfg_wdata at cfg_addr | -
// Path load, append and clear complete in the idle state.
// A pose walks n1 waypoints from the saved index to the end and n2 from the nearest one
// to the target, each read and squared on the shared 33x33 multiplier; then a 33-step
// root, 30 CORDIC steps for bearing, 30 for cosine. Synchronous reset clears path
// state and loads register defaults; the waypoint store is not cleared.
// A result waits in the output register while the next transaction is accepted.
// ----------------------------------------------------------------------------
module lookahead_path_follower #(
  parameter int MAX_WAYPOINTS = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lpf_pkg::IN_DATA_W-1:0]     in_tdata,   // pos_x, pos_y, heading
  input  logic [lpf_pkg::IN_USER_W-1:0]     in_tuser,   // opcode
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lpf_pkg::OUT_DATA_W-1:0]    out_tdata,  // linear_speed, angular_speed
  output logic [lpf_pkg::OUT_USER_W-1:0]    out_tuser,  // at_goal, following
  input  logic                              cfg_we,
  input  logic [lpf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [lpf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import lpf_pkg::*;

  localparam int IDX_W = $clog2(MAX_WAYPOINTS);
  localparam int LEN_W = $clog2(MAX_WAYPOINTS + 1);

  state_t state_r, state_nxt;

  logic [30:0] look_r, tol_r, maxlin_r, maxang_r, lgain_r, again_r;
  logic [15:0] thr_r;

  logic [LEN_W-1:0] path_len_r, last_len;
  logic [IDX_W-1:0] prog_r, idx_r, best_r, last_idx, best_start, best_new;
  logic             active_r, goal_r, pass2_r, first_r;

  logic [31:0] x_mem [MAX_WAYPOINTS];
  logic [31:0] y_mem [MAX_WAYPOINTS];
  logic [31:0] rdx_r, rdy_r;

  logic signed [31:0] px_r, py_r;
  logic [15:0]        yaw_r;

  logic signed [32:0] dx_r, dy_r, tgt_dx_r, tgt_dy_r;
  logic [32:0]        ux, uy;
  logic [63:0]        sx_r;
  logic [64:0]        d_sum, best_d_r, tgt_d_r;
  logic [61:0]        g2_r, l2_r;
  logic               less, is_last, hit;

  logic [32:0] mul_a, mul_b;
  logic [65:0] prod_r;

  logic [65:0] sq_r;
  logic [35:0] rem_r, remx, trial;
  logic [32:0] root_r;
  logic [5:0]  cnt_r;

  logic        zero_vec_r, neg_r;
  logic [15:0] emag_r, bear, err;
  logic [31:0] zr;
  logic [35:0] rad_sum;
  logic [18:0] rad_r;
  logic [30:0] angm_r, lin_r, cos_r;

  logic [30:0] res_lin_r;
  logic [31:0] res_ang_r;
  logic        res_goal_r, res_fol_r;

  logic [30:0] out_lin_r;
  logic [31:0] out_ang_r;
  logic        out_goal_r, out_fol_r, out_valid_r;

  logic                   in_acc;
  op_t                    op;
  cordic_ctl_t            c_ctl;
  logic signed [CX_W-1:0] c_x, c_y, c_xo;
  logic signed [CZ_W-1:0] c_z, c_zo;
  logic                   c_busy;

  lpf_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (c_ctl),
    .x_in  (c_x),
    .y_in  (c_y),
    .z_in  (c_z),
    .busy  (c_busy),
    .x_out (c_xo),
    .z_out (c_zo)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign op        = op_t'(in_tuser);

  assign last_len   = path_len_r - LEN_W'(1);
  assign last_idx   = last_len[IDX_W-1:0];
  assign best_start = ({1'b0, prog_r} > (IDX_W+1)'(last_len)) ? last_idx : prog_r;
  assign is_last    = (idx_r == last_idx);

  assign ux    = dx_r[32] ? 33'(-dx_r) : 33'(dx_r);
  assign uy    = dy_r[32] ? 33'(-dy_r) : 33'(dy_r);
  assign d_sum = {1'b0, sx_r} + {1'b0, prod_r[63:0]};
  assign less  = d_sum < best_d_r;
  assign best_new = (first_r || less) ? idx_r : best_r;
  assign hit   = d_sum[64] || (d_sum[63:0] >= {2'b00, l2_r});

  assign remx  = {rem_r[33:0], sq_r[65:64]};
  assign trial = {1'b0, root_r, 2'b01};

  assign zr      = c_zo[31:0] + 32'h0000_8000;
  assign bear    = zero_vec_r ? 16'h0 : zr[31:16];
  assign err     = bear - yaw_r;
  assign rad_sum = {1'b0, prod_r[34:0]} + 36'd32768;

  always_comb begin
    state_nxt = state_r;
    mul_a     = '0;
    mul_b     = '0;
    c_ctl     = '0;
    c_x       = '0;
    c_y       = '0;
    c_z       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && op == OP_POSE) begin
          if (!active_r || path_len_r == '0 || goal_r) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_G2;
          end
        end
      end
      ST_G2: begin
        mul_a     = {2'b00, tol_r};
        mul_b     = {2'b00, tol_r};
        state_nxt = ST_L2;
      end
      ST_L2: begin
        mul_a     = {2'b00, look_r};
        mul_b     = {2'b00, look_r};
        state_nxt = ST_L2W;
      end
      ST_L2W:  state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_DIFF;
      ST_DIFF: state_nxt = ST_SQX;
      ST_SQX: begin
        mul_a     = ux;
        mul_b     = ux;
        state_nxt = ST_SQY;
      end
      ST_SQY: begin
        mul_a     = uy;
        mul_b     = uy;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        if (!pass2_r) begin
          if (is_last) begin
            if (!d_sum[64] && d_sum[63:0] <= {2'b00, g2_r}) begin
              state_nxt = ST_OUT;
            end else begin
              state_nxt = ST_RD;
            end
          end else begin
            state_nxt = ST_RD;
          end
        end else if (hit || is_last) begin
          state_nxt = ST_SQRT;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_SQRT: begin
        if (cnt_r == '0) begin
          state_nxt = ST_BSTART;
        end
      end
      ST_BSTART: begin
        c_ctl.start = !(tgt_dx_r == '0 && tgt_dy_r == '0);
        c_ctl.vec   = 1'b1;
        c_x = tgt_dx_r[32] ? CX_W'(-tgt_dx_r) : CX_W'(tgt_dx_r);
        c_y = tgt_dx_r[32] ? CX_W'(-tgt_dy_r) : CX_W'(tgt_dy_r);
        c_z = tgt_dx_r[32] ? $signed({1'b0, 32'h8000_0000}) : '0;
        state_nxt = ST_BWAIT;
      end
      ST_BWAIT: begin
        if (!c_busy) begin
          state_nxt = ST_RAD;
        end
      end
      ST_RAD: begin
        mul_a     = {17'd0, emag_r};
        mul_b     = {14'd0, TWO_PI_Q16};
        state_nxt = ST_RADW;
      end
      ST_RADW: state_nxt = ST_ANG;
      ST_ANG: begin
        mul_a     = {2'b00, again_r};
        mul_b     = {14'd0, rad_r};
        state_nxt = ST_LIN;
      end
      ST_LIN: begin
        mul_a     = {2'b00, lgain_r};
        mul_b     = root_r;
        state_nxt = ST_CSTART;
      end
      ST_CSTART: begin
        c_ctl.start = (emag_r < QUARTER_TURN);
        c_ctl.vec   = 1'b0;
        c_x         = $signed({4'd0, CORDIC_K_Q30});
        c_y         = '0;
        c_z         = $signed({1'b0, emag_r, 16'd0});
        state_nxt   = ST_CWAIT;
      end
      ST_CWAIT: begin
        if (!c_busy) begin
          state_nxt = ST_MULC;
        end
      end
      ST_MULC: begin
        mul_a     = {2'b00, lin_r};
        mul_b     = {2'b00, cos_r};
        state_nxt = ST_FIN;
      end
      ST_FIN: state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    rdx_r  <= x_mem[idx_r];
    rdy_r  <= y_mem[idx_r];
    if (in_acc && op == OP_START) begin
      x_mem[0] <= in_tdata[31:0];
      y_mem[0] <= in_tdata[63:32];
    end else if (in_acc && op == OP_APPEND && active_r &&
                 path_len_r < LEN_W'(MAX_WAYPOINTS)) begin
      x_mem[path_len_r[IDX_W-1:0]] <= in_tdata[31:0];
      y_mem[path_len_r[IDX_W-1:0]] <= in_tdata[63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      look_r   <= 31'd65536;
      tol_r    <= 31'd13107;
      maxlin_r <= 31'd32768;
      maxang_r <= 31'd65536;
      lgain_r  <= 31'd65536;
      again_r  <= 31'd131072;
      thr_r    <= 16'd8192;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_LOOKAHEAD: look_r   <= cfg_wdata;
        CFG_GOAL_TOL:  tol_r    <= cfg_wdata;
        CFG_MAX_LIN:   maxlin_r <= cfg_wdata;
        CFG_MAX_ANG:   maxang_r <= cfg_wdata;
        CFG_LIN_GAIN:  lgain_r  <= cfg_wdata;
        CFG_ANG_GAIN:  again_r  <= cfg_wdata;
        CFG_TURN_THR:  thr_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      path_len_r  <= '0;
      prog_r      <= '0;
      active_r    <= 1'b0;
      goal_r      <= 1'b0;
      pass2_r     <= 1'b0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            case (op)
              OP_START: begin
                path_len_r <= LEN_W'(1);
                prog_r     <= '0;
                active_r   <= 1'b1;
                goal_r     <= 1'b0;
              end
              OP_APPEND: begin
                if (active_r && path_len_r < LEN_W'(MAX_WAYPOINTS)) begin
                  path_len_r <= path_len_r + LEN_W'(1);
                end
              end
              OP_CLEAR: begin
                path_len_r <= '0;
                prog_r     <= '0;
                active_r   <= 1'b0;
                goal_r     <= 1'b0;
              end
              default: begin
                px_r       <= $signed(in_tdata[31:0]);
                py_r       <= $signed(in_tdata[63:32]);
                yaw_r      <= in_tdata[79:64];
                idx_r      <= best_start;
                pass2_r    <= 1'b0;
                first_r    <= 1'b1;
                res_lin_r  <= '0;
                res_ang_r  <= '0;
                res_goal_r <= active_r && path_len_r != '0 && goal_r;
                res_fol_r  <= active_r && path_len_r != '0 && goal_r;
              end
            endcase
          end
        end
        ST_L2:  g2_r <= prod_r[61:0];
        ST_L2W: l2_r <= prod_r[61:0];
        ST_DIFF: begin
          dx_r <= $signed({rdx_r[31], rdx_r}) - $signed({px_r[31], px_r});
          dy_r <= $signed({rdy_r[31], rdy_r}) - $signed({py_r[31], py_r});
        end
        ST_SQY: sx_r <= prod_r[63:0];
        ST_SUM: begin
          first_r <= 1'b0;
          if (!pass2_r) begin
            if (first_r || less) begin
              best_d_r <= d_sum;
              best_r   <= idx_r;
            end
            if (is_last) begin
              tgt_dx_r <= dx_r;
              tgt_dy_r <= dy_r;
              tgt_d_r  <= d_sum;
              prog_r   <= best_new;
              idx_r    <= best_new;
              pass2_r  <= 1'b1;
              if (!d_sum[64] && d_sum[63:0] <= {2'b00, g2_r}) begin
                goal_r     <= 1'b1;
                res_lin_r  <= '0;
                res_ang_r  <= '0;
                res_goal_r <= 1'b1;
                res_fol_r  <= 1'b1;
              end
            end else begin
              idx_r <= idx_r + IDX_W'(1);
            end
          end else begin
            if (hit) begin
              tgt_dx_r <= dx_r;
              tgt_dy_r <= dy_r;
            end else if (!is_last) begin
              idx_r <= idx_r + IDX_W'(1);
            end
            sq_r   <= {1'b0, (hit ? d_sum : tgt_d_r)};
            rem_r  <= '0;
            root_r <= '0;
            cnt_r  <= 6'd32;
          end
        end
        ST_SQRT: begin
          if (remx >= trial) begin
            rem_r  <= remx - trial;
            root_r <= {root_r[31:0], 1'b1};
          end else begin
            rem_r  <= remx;
            root_r <= {root_r[31:0], 1'b0};
          end
          sq_r  <= {sq_r[63:0], 2'b00};
          cnt_r <= cnt_r - 6'd1;
        end
        ST_BSTART: zero_vec_r <= (tgt_dx_r == '0 && tgt_dy_r == '0);
        ST_BWAIT: begin
          neg_r  <= err[15];
          emag_r <= err[15] ? 16'(-err) : err;
        end
        ST_RADW: rad_r <= rad_sum[34:16];
        ST_LIN: begin
          angm_r <= (prod_r[49:16] > {3'd0, maxang_r}) ? maxang_r : prod_r[46:16];
        end
        ST_CSTART: begin
          lin_r <= (prod_r[63:16] > {17'd0, maxlin_r}) ? maxlin_r : prod_r[46:16];
        end
        ST_CWAIT: begin
          if (emag_r >= QUARTER_TURN || c_xo[CX_W-1]) begin
            cos_r <= '0;
          end else if (c_xo > $signed({5'd0, ONE_Q30})) begin
            cos_r <= ONE_Q30;
          end else begin
            cos_r <= c_xo[30:0];
          end
        end
        ST_FIN: begin
          res_lin_r  <= (emag_r >= thr_r) ? 31'd0 : prod_r[60:30];
          res_ang_r  <= neg_r ? 32'(-{1'b0, angm_r}) : {1'b0, angm_r};
          res_goal_r <= 1'b0;
          res_fol_r  <= 1'b1;
        end
        ST_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_lin_r   <= res_lin_r;
            out_ang_r   <= res_ang_r;
            out_goal_r  <= res_goal_r;
            out_fol_r   <= res_fol_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_ang_r, out_lin_r};
  assign out_tuser  = {out_fol_r, out_goal_r};

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    path_len_r <= LEN_W'(MAX_WAYPOINTS))
    else $error("path length beyond capacity");

  a_prog_in_path: assert property (@(posedge clk) disable iff (!rst_n)
    (path_len_r != '0) |-> ({1'b0, prog_r} < (IDX_W+1)'(path_len_r)))
    else $error("progress index past path end");

  a_goal_active: assert property (@(posedge clk) disable iff (!rst_n)
    goal_r |-> active_r)
    else $error("goal latched without active path");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result raised outside output state");

  a_goal_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_goal_r) |-> (out_fol_r && out_lin_r == '0 && out_ang_r == '0))
    else $error("goal result carries a command");

endmodule
